@@ hw/rtl/pt2_pkg.sv @@
// Shared types, constants and saturation helper for the PT2 lag step block.
// Used by pt2_div and pt2_lag_step; depends on nothing else.
`default_nettype none

package pt2_pkg;

    localparam int DATA_W            = 32;
    localparam int DT_W              = 31;
    localparam int NUM_W             = 33;
    localparam int CFG_IDX_W         = 2;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_INIT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_CONSTANT  = 2'd0,
        REG_DAMPING        = 2'd1,
        REG_GAIN           = 2'd2,
        REG_VELOCITY_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO_T  = 2'd1,
        STATUS_ZERO_DT = 2'd2
    } status_t;

    typedef struct packed {
        logic            opcode;
        q_t              goal_value;
        logic [DT_W-1:0] time_step;
        q_t              start_position;
        q_t              start_velocity;
    } item_t;

    typedef struct packed {
        q_t         position;
        q_t         velocity;
        q_t         acceleration;
        logic       is_initialized;
        logic [1:0] status;
    } result_t;

    function automatic q_t sat_q(input logic signed [63:0] v);
        q_t r;
        if (v > WIDE_MAX) begin
            r = WIDE_MAX[DATA_W-1:0];
        end
        else if (v < WIDE_MIN) begin
            r = WIDE_MIN[DATA_W-1:0];
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pt2_lag_step.sv @@
// Top level of the PT2 second-order lag step block: sequencer, registers and
// shared multiplier. Depends on pt2_pkg and pt2_div.
//
// A step item runs through one shared 32x32 multiplier (its product is registered)
// and one restoring divider that yields a quotient bit per cycle, so the rate
// is set by the divider. An initialize item uses the multiplier only, and an
// item rejected for a zero time constant or zero time step goes straight to
// the output state. The input is stalled while an item is in work; a finished
// result sits in an output register, so the next item is accepted while that
// result waits to be taken.
`default_nettype none

module pt2_lag_step
    import pt2_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 item_valid,
    output      logic                 item_stall,
    input  wire item_t                item,
    output      logic                 result_valid,
    input  wire logic                 result_stall,
    output      result_t              result
);

    localparam q_t ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MAXV  = 12'b0000_0000_0010,
        S_G     = 12'b0000_0000_0100,
        S_DY    = 12'b0000_0000_1000,
        S_KG    = 12'b0000_0001_0000,
        S_DX    = 12'b0000_0010_0000,
        S_GE    = 12'b0000_0100_0000,
        S_YD    = 12'b0000_1000_0000,
        S_INNER = 12'b0001_0000_0000,
        S_ACC   = 12'b0010_0000_0000,
        S_INIT  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t  state_reg;
    logic    phase_reg;
    item_t   item_reg;
    status_t status_reg;

    q_t t_reg;
    q_t d_reg;
    q_t k_reg;
    q_t v_reg;

    q_t   inner_reg;
    q_t   pos_reg;
    q_t   vel_reg;
    q_t   acc_reg;
    logic init_reg;

    q_t maxv_reg;
    q_t g_reg;
    q_t dy_reg;
    q_t kg_reg;
    q_t e_reg;
    q_t xn_reg;
    q_t ydn_reg;

    logic signed [63:0] prod_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    q_t                 mul_a;
    q_t                 mul_b;
    q_t                 qm;
    q_t                 dt_q;
    q_t                 twice_dx;
    q_t                 e_next;
    q_t                 xn_next;
    q_t                 pos_next;
    logic               div_start;
    logic               div_done;
    q_t                 div_quo;
    logic signed [NUM_W-1:0] div_num;
    q_t                 div_den;

    assign dt_q = {1'b0, item_reg.time_step};

    always_comb
    begin
        case (state_reg)
            S_MAXV:
            begin
                mul_a = dt_q;
                mul_b = v_reg;
            end
            S_DY:
            begin
                mul_a = g_reg;
                mul_b = inner_reg;
            end
            S_KG:
            begin
                mul_a = k_reg;
                mul_b = item_reg.goal_value;
            end
            S_DX:
            begin
                mul_a = d_reg;
                mul_b = inner_reg;
            end
            S_GE:
            begin
                mul_a = g_reg;
                mul_b = e_reg;
            end
            S_INNER:
            begin
                mul_a = ydn_reg;
                mul_b = t_reg;
            end
            S_INIT:
            begin
                mul_a = t_reg;
                mul_b = item_reg.start_velocity;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_G:
            begin
                div_num = {2'b00, item_reg.time_step};
                div_den = t_reg;
            end
            S_YD:
            begin
                div_num = {xn_reg[DATA_W-1], xn_reg};
                div_den = t_reg;
            end
            S_ACC:
            begin
                div_num = {ydn_reg[DATA_W-1], ydn_reg} - {vel_reg[DATA_W-1], vel_reg};
                div_den = dt_q;
            end
            default:
            begin
                div_num = '0;
                div_den = t_reg;
            end
        endcase
        div_start = !phase_reg && (state_reg == S_G || state_reg == S_YD
                                   || state_reg == S_ACC);
    end

    always_comb
    begin
        qm       = sat_q(prod_reg >>> FRAC_BITS);
        twice_dx = sat_q({{31{qm[DATA_W-1]}}, qm, 1'b0});
        e_next   = sat_q({{32{kg_reg[DATA_W-1]}}, kg_reg}
                         - {{32{pos_reg[DATA_W-1]}}, pos_reg}
                         - {{32{twice_dx[DATA_W-1]}}, twice_dx});
        xn_next  = sat_q({{32{inner_reg[DATA_W-1]}}, inner_reg}
                         + {{32{qm[DATA_W-1]}}, qm});
        pos_next = sat_q({{32{pos_reg[DATA_W-1]}}, pos_reg}
                         + {{32{dy_reg[DATA_W-1]}}, dy_reg});
    end

    pt2_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            t_reg            <= ONE_Q;
            d_reg            <= ONE_Q;
            k_reg            <= ONE_Q;
            v_reg            <= 32'sh7FFF_FFFF;
            inner_reg        <= '0;
            pos_reg          <= '0;
            vel_reg          <= '0;
            acc_reg          <= '0;
            init_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TIME_CONSTANT:  t_reg <= cfg_data;
                    REG_DAMPING:        d_reg <= cfg_data;
                    REG_GAIN:           k_reg <= cfg_data;
                    REG_VELOCITY_LIMIT: v_reg <= cfg_data;
                    default:            t_reg <= t_reg;
                endcase
            end

            if (result_valid_reg && !result_stall && state_reg != S_OUT)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    phase_reg <= 1'b0;
                    if (item_valid)
                    begin
                        item_reg <= item;
                        if (item.opcode == OP_INIT)
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_INIT;
                        end
                        else if (t_reg == '0)
                        begin
                            status_reg <= STATUS_ZERO_T;
                            state_reg  <= S_OUT;
                        end
                        else if (item.time_step == '0)
                        begin
                            status_reg <= STATUS_ZERO_DT;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_MAXV;
                        end
                    end
                end
                S_MAXV:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        maxv_reg  <= qm;
                        state_reg <= S_G;
                    end
                end
                S_G:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        g_reg     <= div_quo;
                        phase_reg <= 1'b0;
                        state_reg <= S_DY;
                    end
                end
                S_DY:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        dy_reg    <= (qm < maxv_reg) ? qm : maxv_reg;
                        state_reg <= S_KG;
                    end
                end
                S_KG:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        kg_reg    <= qm;
                        state_reg <= S_DX;
                    end
                end
                S_DX:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        e_reg     <= e_next;
                        state_reg <= S_GE;
                    end
                end
                S_GE:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        xn_reg    <= xn_next;
                        state_reg <= S_YD;
                    end
                end
                S_YD:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        ydn_reg   <= (div_quo < v_reg) ? div_quo : v_reg;
                        phase_reg <= 1'b0;
                        state_reg <= S_INNER;
                    end
                end
                S_INNER:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        inner_reg <= qm;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        acc_reg   <= div_quo;
                        vel_reg   <= ydn_reg;
                        pos_reg   <= pos_next;
                        phase_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_INIT:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        inner_reg <= qm;
                        pos_reg   <= item_reg.start_position;
                        vel_reg   <= item_reg.start_velocity;
                        init_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    phase_reg <= 1'b0;
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.position       <= pos_reg;
                        result_reg.velocity       <= vel_reg;
                        result_reg.acceleration   <= acc_reg;
                        result_reg.is_initialized <= init_reg;
                        result_reg.status         <= status_reg;
                        result_valid_reg          <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pt2_div.sv @@
// Sequential signed fixed-point divider: (num * 2^FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. Restoring, one quotient bit per cycle.
// Depends on pt2_pkg.
`default_nettype none

module pt2_div
    import pt2_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire q_t                      den,
    output      logic                    done,
    output      q_t                      quo
);

    localparam int NW    = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dmag_reg;
    q_t                quo_reg;

    logic [NUM_W-1:0]  num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W:0]   rem_next;
    logic signed [63:0] quo_wide;

    always_comb
    begin
        num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        trial    = {rem_reg, dvd_reg[NW-1]};
        fits     = (trial >= {1'b0, dmag_reg});
        rem_next = fits ? (trial - {1'b0, dmag_reg}) : trial;
        quo_wide = neg_reg ? -$signed({{(64-NW){1'b0}}, dvd_reg})
                           : $signed({{(64-NW){1'b0}}, dvd_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
                dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                dmag_reg <= den_mag;
                neg_reg  <= num[NUM_W-1] ^ den[DATA_W-1];
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[NW-2:0], fits};
                rem_reg <= rem_next[DATA_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (fin_reg)
            begin
                quo_reg <= sat_q(quo_wide);
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for pt2_lag_step: random configuration phases, step and
// initialize beats, and a fixed-point predictor held in a small scoreboard class.
// Depends on pt2_pkg and the pt2_lag_step RTL only.
`timescale 1ns / 100ps

module tb;
    import pt2_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam q_t Q_MAX = 32'sh7FFFFFFF;
    localparam q_t Q_MIN = 32'sh80000000;
    localparam q_t Q_ONE = 32'sh00010000;
    localparam logic [DT_W-1:0] DT_MAX = '1;

    class lag_scoreboard;
        q_t t_reg = Q_ONE;
        q_t d_reg = Q_ONE;
        q_t k_reg = Q_ONE;
        q_t v_reg = Q_MAX;
        longint lag = 0;
        longint pos = 0;
        longint vel = 0;
        longint acc = 0;
        bit init_seen = 1'b0;
        result_t expected[$];
        int errors = 0;
        int checked = 0;

        function longint clamp(longint v);
            if (v > WIDE_MAX) return WIDE_MAX;
            if (v < WIDE_MIN) return WIDE_MIN;
            return v;
        endfunction

        function longint fx_mul(longint a, longint b);
            return clamp((a * b) >>> FRAC);
        endfunction

        function longint fx_div(longint a, longint b);
            return clamp((a <<< FRAC) / b);
        endfunction

        function void set_reg(cfg_reg_t idx, q_t val);
            case (idx)
                REG_TIME_CONSTANT:  t_reg = val;
                REG_DAMPING:        d_reg = val;
                REG_GAIN:           k_reg = val;
                REG_VELOCITY_LIMIT: v_reg = val;
                default:            t_reg = t_reg;
            endcase
        endfunction

        function void note_item(item_t it);
            longint dt;
            longint g;
            longint dy;
            longint step_max;
            longint damp;
            longint err;
            longint x_new;
            longint yd_new;
            status_t st;
            result_t r;
            st = STATUS_OK;
            if (it.opcode == OP_INIT) begin
                pos = $signed(it.start_position);
                vel = $signed(it.start_velocity);
                lag = fx_mul(t_reg, vel);
                init_seen = 1'b1;
            end
            else if (t_reg == 0) begin
                st = STATUS_ZERO_T;
            end
            else if (it.time_step == '0) begin
                st = STATUS_ZERO_DT;
            end
            else begin
                dt = it.time_step;
                step_max = fx_mul(dt, t_reg == 0 ? 0 : v_reg);
                g = fx_div(dt, t_reg);
                dy = fx_mul(g, lag);
                if (step_max < dy) dy = step_max;
                damp = clamp(2 * fx_mul(d_reg, lag));
                err = clamp(fx_mul(k_reg, $signed(it.goal_value)) - pos - damp);
                x_new = clamp(lag + fx_mul(g, err));
                yd_new = fx_div(x_new, t_reg);
                if (v_reg < yd_new) yd_new = v_reg;
                lag = fx_mul(yd_new, t_reg);
                acc = fx_div(yd_new - vel, dt);
                vel = yd_new;
                pos = clamp(pos + dy);
            end
            r.position = pos[DATA_W-1:0];
            r.velocity = vel[DATA_W-1:0];
            r.acceleration = acc[DATA_W-1:0];
            r.is_initialized = init_seen;
            r.status = st;
            expected.push_back(r);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                errors++;
                return;
            end
            want = expected.pop_front();
            checked++;
            compare("position", $signed(want.position), $signed(got.position));
            compare("velocity", $signed(want.velocity), $signed(got.velocity));
            compare("acceleration", $signed(want.acceleration), $signed(got.acceleration));
            compare("is_initialized", want.is_initialized, got.is_initialized);
            compare("status", want.status, got.status);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item_bus = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result_bus;

    lag_scoreboard sb;
    bit calm = 1'b0;
    int stall_cnt = 0;

    pt2_lag_step u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall) begin
                sb.check_result(result_bus);
                if (sb.checked % 300 == 150) stall_cnt = 500;
            end
            if (stall_cnt == 0 && !calm && $urandom_range(0, 11) == 0) begin
                stall_cnt = $urandom_range(1, 16);
            end
            result_stall <= (stall_cnt != 0);
            if (stall_cnt != 0) stall_cnt--;
        end
    end

    function automatic q_t rand_word();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic q_t near_zero();
        return q_t'($urandom_range(0, 2097152) - 1048576);
    endfunction

    function automatic item_t make_item(logic op, q_t goal, logic [DT_W-1:0] dt, q_t p, q_t v);
        item_t it;
        it.opcode = op;
        it.goal_value = goal;
        it.time_step = dt;
        it.start_position = p;
        it.start_velocity = v;
        return it;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.opcode = ($urandom_range(0, 9) == 0) ? OP_INIT : OP_STEP;
        it.goal_value = ($urandom_range(0, 4) == 0) ? rand_word() : near_zero();
        case ($urandom_range(0, 19))
            0: it.time_step = '0;
            1: it.time_step = DT_MAX;
            2, 3: it.time_step = DT_W'($urandom);
            default: it.time_step = DT_W'($urandom_range(1, 6554));
        endcase
        it.start_position = ($urandom_range(0, 3) == 0) ? rand_word() : near_zero();
        it.start_velocity = ($urandom_range(0, 3) == 0) ? rand_word() : near_zero();
        return it;
    endfunction

    task automatic put_item(input item_t it);
        item_bus <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_item(it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.expected.size() != 0);
    endtask

    task automatic write_one(input cfg_reg_t idx, input q_t val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_regs(input q_t t, input q_t d, input q_t k, input q_t v);
        write_one(REG_TIME_CONSTANT, t);
        write_one(REG_DAMPING, d);
        write_one(REG_GAIN, k);
        write_one(REG_VELOCITY_LIMIT, v);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        q_t t;
        q_t d;
        q_t k;
        q_t v;
        int phase;
        int n;
        sb = new;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_item(make_item(OP_STEP, '0, 31'd655, $urandom, $urandom));
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), Q_MAX, Q_MIN));
        put_item(make_item(OP_STEP, Q_MAX, DT_MAX, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_MIN, 31'd1, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_ONE, '0, $urandom, $urandom));
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), Q_MIN, Q_MAX));
        put_item(make_item(OP_STEP, Q_MIN, 31'd65536, $urandom, $urandom));
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), '0, '0));
        put_item(make_item(OP_STEP, Q_ONE, 31'd6554, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_ONE, 31'd6554, $urandom, $urandom));
        drain();

        write_regs('0, Q_ONE, Q_ONE, Q_MAX);
        put_item(make_item(OP_STEP, Q_ONE, 31'd100, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_ONE, '0, $urandom, $urandom));
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), 32'sd5, 32'sd7));
        put_item(make_item(OP_STEP, Q_MAX, DT_MAX, $urandom, $urandom));
        drain();

        write_regs(Q_MIN, Q_MAX, Q_MIN, Q_MIN);
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), '0, Q_MAX));
        put_item(make_item(OP_STEP, Q_MAX, DT_MAX, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_MIN, 31'd1, $urandom, $urandom));
        drain();

        write_regs(Q_MAX, Q_MIN, Q_MAX, Q_MAX);
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), Q_MAX, Q_MIN));
        put_item(make_item(OP_STEP, Q_MIN, DT_MAX, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_MAX, 31'd1, $urandom, $urandom));
        drain();

        write_regs(32'sd1, '0, -32'sd1, '0);
        put_item(make_item(OP_INIT, $urandom, DT_W'($urandom), Q_ONE, -Q_ONE));
        put_item(make_item(OP_STEP, Q_MAX, 31'd65536, $urandom, $urandom));
        put_item(make_item(OP_STEP, Q_MIN, 31'd3, $urandom, $urandom));

        for (phase = 0; phase < 12; phase++) begin
            drain();
            if (phase == 11) calm = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    t = rand_word();
                    d = rand_word();
                    k = rand_word();
                    v = rand_word();
                end
                1: begin
                    t = '0;
                    d = rand_word();
                    k = near_zero();
                    v = rand_word();
                end
                default: begin
                    t = $urandom_range(6554, 655360);
                    d = $urandom_range(0, 131072);
                    k = q_t'($urandom_range(0, 262144) - 131072);
                    v = ($urandom_range(0, 3) == 0) ? Q_MAX : q_t'($urandom_range(16384, 4194304));
                end
            endcase
            write_regs(t, d, k, v);
            for (n = 0; n < 75; n++) put_item(rand_item());
        end

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pt2_pkg.sv
hw/rtl/pt2_div.sv
hw/rtl/pt2_lag_step.sv
verif/tb.sv
